// File: src/rles_pkg.sv
// ----------------------------------------------------------------------------
// rles_pkg
// Shared codes and tables for the RGB LED effect sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rles_pkg;

    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned DIV_W   = 16;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned ORDER_W = 3;
    localparam int unsigned NUM_CH  = 3;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MODE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LEVEL = 2'd2;

    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FADE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SEQ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BLINK = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd4;

    localparam logic [ORDER_W-1:0] ORDER_LAST = 3'd5;

    localparam logic [DIV_W-1:0]  DIV_RESET   = 16'd50;
    localparam logic [DUTY_W-1:0] DUTY_FULL   = 8'd255;
    localparam logic [DUTY_W-1:0] SEQ_STEP    = 8'd4;
    localparam logic [DUTY_W-1:0] SEQ_TOP     = 8'd251;
    localparam logic [DUTY_W-1:0] SEQ_BOTTOM  = 8'd3;
    localparam logic [DUTY_W-1:0] BLINK_STEP  = 8'd32;
    localparam logic [DUTY_W-1:0] BLINK_TOP   = 8'd224;
    localparam logic [DUTY_W-1:0] BLINK_FLOOR = 8'd31;

    typedef logic [DUTY_W-1:0] t_duty;
    typedef t_duty [NUM_CH-1:0] t_duty_vec;

    // chain counter shown on a channel for a given sequence order
    function automatic logic [1:0] perm_sel(input logic [ORDER_W-1:0] order,
                                            input int unsigned ch);
        logic [5:0] row;
        begin
            case (order)
                3'd0:    row = {2'd2, 2'd1, 2'd0};
                3'd1:    row = {2'd2, 2'd0, 2'd1};
                3'd2:    row = {2'd0, 2'd1, 2'd2};
                3'd3:    row = {2'd0, 2'd2, 2'd1};
                3'd4:    row = {2'd1, 2'd0, 2'd2};
                3'd5:    row = {2'd1, 2'd2, 2'd0};
                default: row = {2'd2, 2'd1, 2'd0};
            endcase
            perm_sel = row[2*ch +: 2];
        end
    endfunction

endpackage

`default_nettype wire

// File: src/rgb_led_effect_sequencer_top.sv
// ----------------------------------------------------------------------------
// rgb_led_effect_sequencer_top
// Timer-driven RGB effect engine producing three PWM duty levels.
// ----------------------------------------------------------------------------
// Each input word is held in the input register, then passes through the effect
// logic into the result register, which holds its result word.
// A new word is accepted every cycle; the effect state is updated as each word
// moves from the input register to the result register, so the rate is set
// only by the downstream m_axis_tready. Every input word yields one result.
`default_nettype none

module rgb_led_effect_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_tick_div_we,
    input  wire logic [15:0] i_tick_div_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // mode_select[2:0], level[10:3], zero
    input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // red[7:0], green[15:8], blue[23:16],
                                            // mode_now[26:24], zero
    output logic             m_axis_tuser   // duty_written
);

    typedef logic [rles_pkg::DUTY_W-1:0] t_byte;

    logic                            r_in_valid;
    logic [rles_pkg::CMD_W-1:0]      r_in_cmd;
    logic [rles_pkg::MODE_W-1:0]     r_in_sel;
    t_byte                           r_in_level;

    logic                            r_out_valid;
    logic [31:0]                     r_out_data;
    logic                            r_out_user;

    logic [rles_pkg::DIV_W-1:0]      r_divider;
    logic [rles_pkg::DIV_W-1:0]      r_presc,      n_presc;
    logic [rles_pkg::MODE_W-1:0]     r_mode,       n_mode;
    t_byte                           r_max,        n_max;
    t_byte                           r_fade,       n_fade;
    rles_pkg::t_duty_vec             r_chain,      n_chain;
    logic                            r_chain_up,   n_chain_up;
    logic [rles_pkg::ORDER_W-1:0]    r_order,      n_order;
    rles_pkg::t_duty_vec             r_blink,      n_blink;
    logic [rles_pkg::NUM_CH-1:0]     r_blink_up,   n_blink_up;
    rles_pkg::t_duty_vec             r_duty,       n_duty;
    logic                            n_written;

    logic advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_comb begin
        logic moved;
        n_presc    = r_presc;
        n_mode     = r_mode;
        n_max      = r_max;
        n_fade     = r_fade;
        n_chain    = r_chain;
        n_chain_up = r_chain_up;
        n_order    = r_order;
        n_blink    = r_blink;
        n_blink_up = r_blink_up;
        n_duty     = r_duty;
        n_written  = 1'b0;
        moved      = 1'b0;
        case (r_in_cmd)
            rles_pkg::CMD_TICK: begin
                if (r_presc < r_divider) begin
                    n_presc = r_presc + 16'd1;
                end else begin
                    n_presc = '0;
                    case (r_mode)
                        rles_pkg::MODE_FADE: begin
                            n_fade    = r_fade + 8'd1;
                            n_written = 1'b1;
                            for (int i = 0; i < rles_pkg::NUM_CH; i++) begin
                                n_duty[i] = (n_fade > r_max) ? r_max : n_fade;
                            end
                            if (n_fade == rles_pkg::DUTY_FULL) begin
                                n_mode = rles_pkg::MODE_IDLE;
                            end
                        end
                        rles_pkg::MODE_SEQ: begin
                            n_written = 1'b1;
                            for (int i = 0; i < rles_pkg::NUM_CH; i++) begin
                                if (!moved) begin
                                    if (r_chain_up) begin
                                        if (r_chain[i] < rles_pkg::SEQ_TOP) begin
                                            n_chain[i] = r_chain[i] + rles_pkg::SEQ_STEP;
                                            moved      = 1'b1;
                                        end
                                    end else if (r_chain[i] > rles_pkg::SEQ_BOTTOM) begin
                                        n_chain[i] = r_chain[i] - rles_pkg::SEQ_STEP;
                                        moved      = 1'b1;
                                    end
                                end
                            end
                            if (!moved) begin
                                n_chain_up = !r_chain_up;
                                n_order    = (r_order >= rles_pkg::ORDER_LAST) ? '0
                                             : r_order + 3'd1;
                            end
                            for (int i = 0; i < rles_pkg::NUM_CH; i++) begin
                                n_duty[i] = n_chain[rles_pkg::perm_sel(n_order, i)];
                            end
                        end
                        rles_pkg::MODE_BLINK: begin
                            n_written = 1'b1;
                            for (int i = 0; i < rles_pkg::NUM_CH; i++) begin
                                if (r_blink_up[i]) begin
                                    if (r_blink[i] < rles_pkg::BLINK_TOP) begin
                                        n_blink[i] = r_blink[i] + rles_pkg::BLINK_STEP;
                                    end else begin
                                        n_blink_up[i] = 1'b0;
                                        n_blink[i]    = rles_pkg::DUTY_FULL;
                                    end
                                end else if (r_blink[i] > rles_pkg::BLINK_FLOOR) begin
                                    n_blink[i] = r_blink[i] - rles_pkg::BLINK_STEP;
                                end else begin
                                    n_blink_up[i] = 1'b1;
                                    n_blink[i]    = '0;
                                end
                            end
                            n_duty[0] = n_blink[2];
                            n_duty[1] = n_blink[1];
                            n_duty[2] = n_blink[0];
                        end
                        rles_pkg::MODE_OFF: begin
                            n_written = 1'b1;
                            n_duty    = '0;
                            n_mode    = rles_pkg::MODE_IDLE;
                        end
                        default: begin
                            n_written = 1'b0;
                        end
                    endcase
                end
            end
            rles_pkg::CMD_MODE: begin
                if (r_in_sel <= rles_pkg::MODE_OFF) begin
                    n_mode     = r_in_sel;
                    n_fade     = '0;
                    n_chain    = {rles_pkg::NUM_CH{rles_pkg::DUTY_FULL}};
                    n_blink    = {rles_pkg::NUM_CH{rles_pkg::DUTY_FULL}};
                    n_chain_up = 1'b0;
                    n_blink_up = '0;
                    n_order    = '0;
                end
            end
            rles_pkg::CMD_LEVEL: begin
                n_max = r_in_level;
                if (r_mode == rles_pkg::MODE_IDLE) begin
                    n_duty    = {rles_pkg::NUM_CH{r_in_level}};
                    n_written = 1'b1;
                end
            end
            default: begin
                n_written = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_divider   <= rles_pkg::DIV_RESET;
            r_presc     <= '0;
            r_mode      <= rles_pkg::MODE_IDLE;
            r_max       <= rles_pkg::DUTY_FULL;
            r_fade      <= '0;
            r_chain     <= {rles_pkg::NUM_CH{rles_pkg::DUTY_FULL}};
            r_chain_up  <= 1'b0;
            r_order     <= '0;
            r_blink     <= {rles_pkg::NUM_CH{rles_pkg::DUTY_FULL}};
            r_blink_up  <= '0;
            r_duty      <= '0;
        end else begin
            if (i_tick_div_we) begin
                r_divider <= i_tick_div_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_presc     <= n_presc;
                r_mode      <= n_mode;
                r_max       <= n_max;
                r_fade      <= n_fade;
                r_chain     <= n_chain;
                r_chain_up  <= n_chain_up;
                r_order     <= n_order;
                r_blink     <= n_blink;
                r_blink_up  <= n_blink_up;
                r_duty      <= n_duty;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd   <= s_axis_tuser;
            r_in_sel   <= s_axis_tdata[2:0];
            r_in_level <= s_axis_tdata[10:3];
        end
        if (advance) begin
            r_out_data <= {5'd0, n_mode, n_duty[2], n_duty[1], n_duty[0]};
            r_out_user <= n_written;
        end
    end

    // the sequence order stays within its six permutations
    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_order <= rles_pkg::ORDER_LAST)
        else $error("sequence order out of range");

    // the mode register only holds defined modes
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= rles_pkg::MODE_OFF)
        else $error("mode register out of range");

    // a valid mode selection clears the effect counters
    a_select_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_cmd == rles_pkg::CMD_MODE && r_in_sel <= rles_pkg::MODE_OFF
        |=> r_fade == '0 && r_order == '0 && !r_chain_up && r_blink_up == '0)
        else $error("mode selection did not clear effect state");

    // a fade step drives all channels to the same level
    a_fade_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_mode == rles_pkg::MODE_FADE && n_written
        |=> r_duty[0] == r_duty[1] && r_duty[1] == r_duty[2])
        else $error("fade step left channels unequal");

    // the result word reports the registered mode and duties
    a_result_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_data[26:24] == r_mode && r_out_data[7:0] == r_duty[0])
        else $error("result word disagrees with state");

endmodule

`default_nettype wire
